FILE: hw/rtl/ictp_pkg.sv
// Shared types and constants of the inline color tag parser.
package ictp_pkg;

  // Longest pattern is the color tag, so the pending buffer holds that many bytes.
  localparam int unsigned TAG_LEN    = 11;
  localparam int unsigned RESET_LEN  = 5;
  localparam int unsigned PEND_DEPTH = TAG_LEN;
  localparam int unsigned CNT_W      = 4;

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_SLASH    = 8'h2F;

  typedef struct packed {
    logic [7:0] char_code;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic [15:0] out_color;
    logic        has_char;
    logic        end_of_text;
    logic        tags_seen;
    logic        last_of_run;
  } out_item_t;

  // One text byte together with its character class.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_lbracket;
    logic       is_rbracket;
    logic       is_hash;
    logic       is_slash;
    logic       is_hex;
    logic [3:0] nib;
  } ent_t;

  typedef struct packed {
    ent_t ent;
    logic last;
  } q_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESOLVE,
    ST_END
  } eng_st_e;

endpackage

FILE: hw/rtl/ictp_fifo.sv
// Small first-in first-out queue of registers.
module ictp_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/ictp_front.sv
// Front end: classifies each incoming byte and queues it for the parse engine.
module ictp_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ictp_pkg::in_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output ictp_pkg::q_item_t  q_o,
  output logic               empty_o
);

  import ictp_pkg::*;

  q_item_t cls;
  logic    is_dig;
  logic    is_alpha_hex;

  always_comb begin
    is_dig       = (item_i.char_code >= 8'h30) && (item_i.char_code <= 8'h39);
    // Upper and lower case letters a to f differ only in bit 5.
    is_alpha_hex = ((item_i.char_code >= 8'h41) && (item_i.char_code <= 8'h46)) ||
                   ((item_i.char_code >= 8'h61) && (item_i.char_code <= 8'h66));
    cls.ent.ch          = item_i.char_code;
    cls.ent.is_lbracket = (item_i.char_code == CH_LBRACKET);
    cls.ent.is_rbracket = (item_i.char_code == CH_RBRACKET);
    cls.ent.is_hash     = (item_i.char_code == CH_HASH);
    cls.ent.is_slash    = (item_i.char_code == CH_SLASH);
    cls.ent.is_hex      = is_dig || is_alpha_hex;
    cls.ent.nib         = is_dig ? item_i.char_code[3:0] : 4'(item_i.char_code[3:0] + 4'd9);
    cls.last            = item_i.text_last;
  end

  ictp_fifo #(
    .W     ($bits(q_item_t)),
    .DEPTH (DEPTH)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .data_o  (q_o),
    .empty_o (empty_o)
  );

endmodule

FILE: hw/rtl/ictp_engine.sv
// Back end: pending buffer, tag matching and result sequencing.
module ictp_engine #(
  parameter int unsigned MAX_CHARS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                front_empty_i,
  input  ictp_pkg::q_item_t   front_item_i,
  output logic                front_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output ictp_pkg::out_item_t res_item_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i
);

  import ictp_pkg::*;

  localparam int unsigned EW = $clog2(MAX_CHARS);

  typedef enum logic [2:0] {
    ACT_STOP,
    ACT_COLOR,
    ACT_RESET,
    ACT_LIMIT,
    ACT_EMIT
  } act_e;

  eng_st_e            st_q, st_d;
  ent_t               buf_q [PEND_DEPTH];
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_after;
  logic [15:0]        cur_color_q, cur_color_d;
  logic [15:0]        dflt_q, dflt_d;
  logic               tag_q, tag_d;
  logic [EW-1:0]      emit_q, emit_d;
  logic               full_q, full_d;
  logic               final_q, final_d;
  logic               held_v_q, held_v_d;
  out_item_t          held_q, held_d;

  logic               color_pfx;
  logic               reset_pfx;
  logic [15:0]        tag_color;
  act_e               act;
  logic               slot_ok;
  logic               drained;
  logic               accept;
  logic               append;
  logic               load_held;
  logic               shift1;
  logic               shift5;

  // Pattern checks over the bytes in use; entries past the count always pass.
  always_comb begin
    logic in_use;
    logic cfit;
    logic rfit;
    color_pfx = 1'b1;
    reset_pfx = 1'b1;
    for (int i = 0; i < PEND_DEPTH; i++) begin
      in_use = (CNT_W'(i) < cnt_q);
      if (i < 2) begin
        cfit = buf_q[i].is_lbracket;
      end else if (i == 2) begin
        cfit = buf_q[i].is_hash;
      end else if (i < 9) begin
        cfit = buf_q[i].is_hex;
      end else begin
        cfit = buf_q[i].is_rbracket;
      end
      if (i < 2) begin
        rfit = buf_q[i].is_lbracket;
      end else if (i == 2) begin
        rfit = buf_q[i].is_slash;
      end else if (i < RESET_LEN) begin
        rfit = buf_q[i].is_rbracket;
      end else begin
        rfit = 1'b1;
      end
      color_pfx = color_pfx && (!in_use || cfit);
      reset_pfx = reset_pfx && (!in_use || rfit);
    end
  end

  // RGB888 from the six digits, packed to RGB565.
  assign tag_color = {buf_q[3].nib, buf_q[4].nib[3],
                      buf_q[5].nib, buf_q[6].nib[3:2],
                      buf_q[7].nib, buf_q[8].nib[3]};

  always_comb begin
    if ((cnt_q == '0) || full_q) begin
      act = ACT_STOP;
    end else if ((cnt_q == CNT_W'(TAG_LEN)) && color_pfx) begin
      act = ACT_COLOR;
    end else if ((cnt_q >= CNT_W'(RESET_LEN)) && reset_pfx) begin
      act = ACT_RESET;
    end else if (!final_q && (cnt_q < CNT_W'(TAG_LEN)) && (color_pfx || reset_pfx)) begin
      act = ACT_STOP;
    end else if (emit_q >= EW'(MAX_CHARS - 1)) begin
      act = ACT_LIMIT;
    end else begin
      act = ACT_EMIT;
    end
  end

  always_comb begin
    case (act)
      ACT_COLOR: cnt_after = '0;
      ACT_RESET: cnt_after = CNT_W'(cnt_q - CNT_W'(RESET_LEN));
      ACT_EMIT:  cnt_after = CNT_W'(cnt_q - 1'b1);
      ACT_LIMIT: cnt_after = '0;
      default:   cnt_after = cnt_q;
    endcase
  end

  assign drained = (cnt_after == '0);
  // A new result may be formed once the held one can move into the result queue.
  assign slot_ok = !held_v_q || !res_full_i;

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (slot_ok && !front_empty_i) begin
          st_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        case (act)
          ACT_STOP, ACT_LIMIT: begin
            st_d = final_q ? ST_END : ST_IDLE;
          end
          ACT_COLOR, ACT_RESET: begin
            if (drained) begin
              st_d = final_q ? ST_END : ST_IDLE;
            end
          end
          ACT_EMIT: begin
            if (slot_ok && drained) begin
              st_d = final_q ? ST_END : ST_IDLE;
            end
          end
          default: st_d = ST_IDLE;
        endcase
      end
      ST_END: begin
        if (slot_ok) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Outputs and strobes.
  always_comb begin
    accept      = 1'b0;
    load_held   = 1'b0;
    shift1      = 1'b0;
    shift5      = 1'b0;
    res_push_o  = 1'b0;
    res_item_o  = held_q;
    case (st_q)
      ST_IDLE: begin
        accept     = slot_ok && !front_empty_i;
        // The held result was the final one of its byte.
        res_push_o = held_v_q && !res_full_i;
        res_item_o.last_of_run = 1'b1;
      end
      ST_RESOLVE: begin
        if (act == ACT_EMIT) begin
          res_push_o = held_v_q && !res_full_i;
          load_held  = slot_ok;
          shift1     = slot_ok;
        end
        shift5 = (act == ACT_RESET);
      end
      ST_END: begin
        res_push_o = held_v_q && !res_full_i;
        load_held  = slot_ok;
      end
      default: begin
        accept = 1'b0;
      end
    endcase
    front_pop_o = accept;
  end

  assign append = accept && !full_q && (cnt_q < CNT_W'(TAG_LEN));

  // Next values of the control and color registers.
  always_comb begin
    cnt_d       = cnt_q;
    cur_color_d = cur_color_q;
    dflt_d      = dflt_q;
    tag_d       = tag_q;
    emit_d      = emit_q;
    full_d      = full_q;
    final_d     = final_q;
    held_v_d    = held_v_q;
    held_d      = held_q;
    if (res_push_o) begin
      held_v_d = 1'b0;
    end
    if (load_held) begin
      held_v_d = 1'b1;
    end
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          final_d = front_item_i.last;
        end
        if (append) begin
          cnt_d = CNT_W'(cnt_q + 1'b1);
        end
      end
      ST_RESOLVE: begin
        case (act)
          ACT_COLOR: begin
            cur_color_d = tag_color;
            tag_d       = 1'b1;
            cnt_d       = cnt_after;
          end
          ACT_RESET: begin
            cur_color_d = dflt_q;
            tag_d       = 1'b1;
            cnt_d       = cnt_after;
          end
          ACT_LIMIT: begin
            full_d = 1'b1;
            cnt_d  = cnt_after;
          end
          ACT_EMIT: begin
            if (slot_ok) begin
              emit_d = EW'(emit_q + 1'b1);
              cnt_d  = cnt_after;
              held_d = '{out_char: buf_q[0].ch, out_color: cur_color_q, has_char: 1'b1,
                         end_of_text: 1'b0, tags_seen: tag_q, last_of_run: 1'b0};
            end
          end
          default: begin
            cnt_d = cnt_q;
          end
        endcase
      end
      ST_END: begin
        if (slot_ok) begin
          held_d = '{out_char: 8'd0, out_color: 16'd0, has_char: 1'b0,
                     end_of_text: 1'b1, tags_seen: tag_q, last_of_run: 1'b0};
          cnt_d       = '0;
          tag_d       = 1'b0;
          emit_d      = '0;
          full_d      = 1'b0;
          cur_color_d = dflt_q;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
    if (cfg_we_i) begin
      dflt_d      = cfg_data_i;
      cur_color_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      cur_color_q <= '0;
      dflt_q      <= '0;
      tag_q       <= 1'b0;
      emit_q      <= '0;
      full_q      <= 1'b0;
      final_q     <= 1'b0;
      held_v_q    <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      cur_color_q <= cur_color_d;
      dflt_q      <= dflt_d;
      tag_q       <= tag_d;
      emit_q      <= emit_d;
      full_q      <= full_d;
      final_q     <= final_d;
      held_v_q    <= held_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    if (append) begin
      buf_q[cnt_q] <= front_item_i.ent;
    end else if (shift1) begin
      for (int i = 0; i < PEND_DEPTH - 1; i++) begin
        buf_q[i] <= buf_q[i + 1];
      end
    end else if (shift5) begin
      for (int i = 0; i < PEND_DEPTH - RESET_LEN; i++) begin
        buf_q[i] <= buf_q[i + RESET_LEN];
      end
    end
  end

endmodule

FILE: hw/rtl/inline_color_tag_parser.sv
// Top level of the inline color tag parser: front queue, parse engine, result queue.
//
//   channel   direction  handshake                 payload
//   input     in         push / full               in_item_i  (char_code, text_last)
//   result    out        empty / pop               out_item_o (char, color, flags)
//   config    in         cfg_valid_i / cfg_ready_o cfg_data_i (default_color)
//
// A byte leaves the input queue in the idle state, then one match step per cycle, unless
// the result queue is full, emits a character, applies a tag or stops; a stop or the step
// that empties the buffer ends the byte. The last byte of a text adds an end state.
// Reset clears all control state; no clearing pass is needed.
// Input and result queues let either side stall without stopping the other; the engine
// waits when the result queue is full or the input queue is empty.
module inline_color_tag_parser #(
  parameter int unsigned MAX_CHARS = 128,
  parameter int unsigned IN_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ictp_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output ictp_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  import ictp_pkg::*;

  q_item_t   front_item;
  logic      front_empty;
  logic      front_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res_item;

  // The user must write the register only while the block is idle; the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  ictp_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item_i),
    .full_o  (full),
    .pop_i   (front_pop),
    .q_o     (front_item),
    .empty_o (front_empty)
  );

  ictp_engine #(
    .MAX_CHARS (MAX_CHARS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .front_empty_i (front_empty),
    .front_item_i  (front_item),
    .front_pop_o   (front_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_item_o    (res_item),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  ictp_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_pop |-> !front_empty) else $error("engine took from an empty input queue");

  a_record_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_item.has_char != res_item.end_of_text))
    else $error("result is neither a character nor an end record");

  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_item.end_of_text) |-> res_item.last_of_run)
    else $error("end record not marked as the final result of its byte");

endmodule

FILE: tb/inline_color_tag_parser_test.sv
// Self-checking testbench of the inline color tag parser with its own scoreboard and drivers.
module inline_color_tag_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ictp_pkg::*;

  // A small character limit lets the discard behavior show up in ordinary texts.
  localparam int unsigned TB_MAX_CHARS = 24;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned PHASE_BYTES  = 32;

  typedef enum int {
    PH_DIRECTED,
    PH_RX_SLOW,
    PH_TX_SLOW,
    PH_FULL_RATE
  } stim_phase_e;

  // Tracks the parser state and holds the records that accepted bytes should produce.
  class color_text_board;
    bit [7:0]    pend[TAG_LEN];
    int unsigned pend_cnt;
    bit [15:0]   dflt_color;
    bit [15:0]   cur_color;
    bit          tag_hit;
    bit          limit_hit;
    int unsigned emitted;
    out_item_t   expected_q[$];
    out_item_t   held;
    bit          have_held;
    int unsigned errors;

    function bit is_hex(bit [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function bit [3:0] hex_val(bit [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      return 4'(c - "A" + 10);
    endfunction

    function bit color_fits(int unsigned p, bit [7:0] c);
      if (p < 2) return c == CH_LBRACKET;
      if (p == 2) return c == CH_HASH;
      if (p < 9) return is_hex(c);
      return c == CH_RBRACKET;
    endfunction

    function bit color_prefix();
      for (int unsigned i = 0; i < pend_cnt && i < TAG_LEN; i++)
        if (!color_fits(i, pend[i])) return 1'b0;
      return 1'b1;
    endfunction

    function bit reset_prefix();
      bit [7:0] pat[RESET_LEN];
      pat = '{CH_LBRACKET, CH_LBRACKET, CH_SLASH, CH_RBRACKET, CH_RBRACKET};
      for (int unsigned i = 0; i < pend_cnt && i < RESET_LEN; i++)
        if (pend[i] != pat[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void drop(int unsigned n);
      if (n >= pend_cnt) begin
        pend_cnt = 0;
        return;
      end
      for (int unsigned i = 0; i < pend_cnt - n; i++) pend[i] = pend[i + n];
      pend_cnt -= n;
    endfunction

    // The newest record is held back until the byte is done, so that it can carry
    // the end-of-run mark.
    function void emit(bit [7:0] ch, bit [15:0] col, bit has, bit endt);
      if (have_held) expected_q.push_back(held);
      held = '{out_char: ch, out_color: col, has_char: has, end_of_text: endt,
               tags_seen: tag_hit, last_of_run: 1'b0};
      have_held = 1'b1;
    endfunction

    function void resolve(bit final_byte);
      bit [7:0] red, grn, blu;
      while (pend_cnt > 0 && !limit_hit) begin
        if (pend_cnt >= TAG_LEN && color_prefix()) begin
          red = {hex_val(pend[3]), hex_val(pend[4])};
          grn = {hex_val(pend[5]), hex_val(pend[6])};
          blu = {hex_val(pend[7]), hex_val(pend[8])};
          cur_color = {red[7:3], grn[7:2], blu[7:3]};
          tag_hit = 1'b1;
          drop(TAG_LEN);
          continue;
        end
        if (pend_cnt >= RESET_LEN && reset_prefix()) begin
          cur_color = dflt_color;
          tag_hit = 1'b1;
          drop(RESET_LEN);
          continue;
        end
        if (!final_byte && pend_cnt < TAG_LEN && (color_prefix() || reset_prefix())) break;
        if (emitted >= TB_MAX_CHARS - 1) begin
          limit_hit = 1'b1;
          pend_cnt = 0;
          break;
        end
        emit(pend[0], cur_color, 1'b1, 1'b0);
        emitted++;
        drop(1);
      end
    endfunction

    function void set_default(bit [15:0] color);
      dflt_color = color;
      cur_color = color;
    endfunction

    function void note_byte(in_item_t item);
      if (!limit_hit && pend_cnt < TAG_LEN) begin
        pend[pend_cnt] = item.char_code;
        pend_cnt++;
      end
      resolve(item.text_last);
      if (item.text_last) begin
        emit(8'h00, 16'h0000, 1'b0, 1'b1);
        pend_cnt = 0;
        tag_hit = 1'b0;
        emitted = 0;
        limit_hit = 1'b0;
        cur_color = dflt_color;
      end
      if (have_held) begin
        held.last_of_run = 1'b1;
        expected_q.push_back(held);
        have_held = 1'b0;
      end
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_record(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected record, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("out_char", 16'(want.out_char), 16'(got.out_char));
      compare("out_color", want.out_color, got.out_color);
      compare("has_char", 16'(want.has_char), 16'(got.has_char));
      compare("end_of_text", 16'(want.end_of_text), 16'(got.end_of_text));
      compare("tags_seen", 16'(want.tags_seen), 16'(got.tags_seen));
      compare("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_item_t    in_item_i;
  logic        empty;
  logic        pop;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  color_text_board board;
  stim_phase_e     stim_phase;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  int unsigned     bytes_sent;
  int unsigned     text_left;

  inline_color_tag_parser #(
    .MAX_CHARS(TB_MAX_CHARS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.set_default(cfg_data_i);
      if (push && !full) board.note_byte(in_item_i);
      if (pop && !empty) board.check_record(out_item_o);
    end
  end

  // Result side; one long hold-off at the start of the full-rate phase fills the block.
  initial begin : receiver
    bit          long_hold_done;
    int unsigned hold_left;
    long_hold_done = 1'b0;
    hold_left = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stim_phase == PH_FULL_RATE && !long_hold_done) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("inline_color_tag_parser_test NOT OK");
    $finish;
  end

  function automatic logic [7:0] hex_char(int unsigned n);
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[n];
  endfunction

  // Most texts are short; one in four runs past the character limit.
  function automatic int unsigned new_text_len();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 6);
      3:       return $urandom_range(30, 45);
      default: return $urandom_range(7, 25);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= '{char_code: ch, text_last: last};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic put_text_byte(input logic [7:0] ch);
    text_left--;
    send_byte(ch, text_left == 0);
    if (text_left == 0) text_left = new_text_len();
  endtask

  task automatic put_string(input string s);
    for (int i = 0; i < s.len(); i++) put_text_byte(s[i]);
  endtask

  // A broken tag stops at a random position and continues with an arbitrary byte.
  task automatic put_tag(input bit is_color, input bit broken);
    logic [7:0]  tag_bytes[$];
    int unsigned cut;
    if (is_color) begin
      tag_bytes = '{CH_LBRACKET, CH_LBRACKET, CH_HASH};
      repeat (6) tag_bytes.push_back(hex_char($urandom_range(0, 21)));
      tag_bytes.push_back(CH_RBRACKET);
      tag_bytes.push_back(CH_RBRACKET);
    end else begin
      tag_bytes = '{CH_LBRACKET, CH_LBRACKET, CH_SLASH, CH_RBRACKET, CH_RBRACKET};
    end
    cut = broken ? $urandom_range(1, tag_bytes.size() - 1) : tag_bytes.size();
    for (int unsigned i = 0; i < cut; i++) put_text_byte(tag_bytes[i]);
    if (broken) put_text_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_default(input logic [15:0] color);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= color;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input stim_phase_e ph, input int unsigned tx_pct,
                           input int unsigned rx_pct, input logic [15:0] color);
    int unsigned start;
    int unsigned pick;
    push <= 1'b0;
    wait_idle();
    write_default(color);
    stim_phase = ph;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) put_text_byte(8'($urandom_range(0, 255)));
      else if (pick < 65) put_tag(1'b1, 1'b0);
      else if (pick < 75) put_tag(1'b0, 1'b0);
      else if (pick < 90) put_tag(1'($urandom_range(0, 1)), 1'b1);
      else begin
        case ($urandom_range(0, 3))
          0:       put_text_byte(CH_LBRACKET);
          1:       put_text_byte(CH_RBRACKET);
          2:       put_text_byte(CH_HASH);
          default: put_text_byte(CH_SLASH);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    board = new();
    stim_phase = PH_DIRECTED;
    tx_idle_pct = 9;
    rx_idle_pct = 48;
    bytes_sent = 0;
    rst_ni <= 1'b0;
    push <= 1'b0;
    in_item_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_default(16'hFFFF);

    // Extreme bytes around a mixed-case color tag and a reset tag, then a failed
    // partial tag flushed at the end of the text.
    text_left = 20;
    put_text_byte(8'h00);
    put_string("[[#FFa0C3]]");
    put_text_byte(8'hFF);
    put_string("[[/]]");
    put_string("[]");
    // A reset tag that completes on the final byte is applied during the flush.
    text_left = 5;
    put_string("[[/]]");

    run_phase(PH_RX_SLOW, 9, 48, 16'h0000);
    run_phase(PH_TX_SLOW, 48, 9, 16'($urandom_range(0, 16'hFFFF)));
    run_phase(PH_FULL_RATE, 0, 0, 16'($urandom_range(0, 16'hFFFF)));
    text_left = 1;
    put_text_byte(".");
    push <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("inline_color_tag_parser_test OK");
    end else begin
      $display("inline_color_tag_parser_test NOT OK");
    end
    $finish;
  end

endmodule
